// File: design/pts_pkg.sv
// Package for the priority task scheduler: types, opcodes, status codes.
// No dependencies.
`default_nettype none
package pts_pkg;
  localparam logic [2:0] OP_CREATE = 3'd0;
  localparam logic [2:0] OP_START  = 3'd1;
  localparam logic [2:0] OP_TICK   = 3'd2;
  localparam logic [2:0] OP_BLOCK  = 3'd3;
  localparam logic [2:0] OP_RESUME = 3'd4;

  localparam logic [1:0] RES_DONE    = 2'd0;
  localparam logic [1:0] RES_FULL    = 2'd1;
  localparam logic [1:0] RES_IGNORED = 2'd2;

  localparam logic [1:0] TS_READY   = 2'd0;
  localparam logic [1:0] TS_RUNNING = 2'd1;
  localparam logic [1:0] TS_BLOCKED = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture input item, set up decode
    logic step;      // walk one table entry
    logic finish;    // commit the selection
    logic clr_walk;  // reset walk index
  } pts_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic walk_last; // current entry is the last one to visit
    logic need_walk; // decoded item needs table walks
  } pts_stat_t;
endpackage
`default_nettype wire

// File: design/pts_if.sv
// Valid/ready channel interface carrying one input item or one result item.
// Depends on nothing.
`default_nettype none
interface pts_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [2:0]  priority_req;
  logic [31:0] timeout;
  logic [4:0]  task_index;
  modport source (output valid, opcode, priority_req, timeout, task_index, input ready);
  modport sink   (input valid, opcode, priority_req, timeout, task_index, output ready);
endinterface

interface pts_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [4:0]  new_task_index;
  logic [4:0]  running_task;
  logic        switched;
  logic [31:0] tick_count;
  modport source (output valid, status, new_task_index, running_task, switched, tick_count,
                  input ready);
  modport sink   (input valid, status, new_task_index, running_task, switched, tick_count,
                  output ready);
endinterface
`default_nettype wire

// File: design/priority_task_scheduler_top.sv
// Top level of the priority task scheduler.
// Depends on pts_pkg, pts_if, pts_ctrl and pts_dp.
//
// Usage: items arrive on in_ch (valid/ready) with an opcode and operands;
// each gives exactly one result on out_ch.
// An item is taken only when the block is idle. Create, resume and
// ignored items go from the walk state straight to finish and then output.
// Tick, block and start, when they take effect, walk the task table once,
// one entry a cycle (countdown and priority search share the walk), then
// finish and present their result. The block returns to idle after each
// taken result before it takes another item. The result is held in
// registers until out_ch.ready; no new item is taken while it waits, so
// a stalled receiver stalls the input.
// Synchronous reset clears the task count, current task, started flag and
// tick counter; the table itself needs no clearing as only created slots
// are ever read.
`default_nettype none
module priority_task_scheduler_top
  import pts_pkg::*;
#(
  parameter int TASK_SLOTS   = 32,
  parameter int TOP_PRIORITY = 7
) (
  input wire logic clk,
  input wire logic rst_n,
  pts_in_if.sink   in_ch,
  pts_out_if.source out_ch
);
  pts_cmd_t  cmd;
  pts_stat_t stat;

  pts_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .stat, .cmd
  );

  pts_dp #(.TASK_SLOTS(TASK_SLOTS), .TOP_PRIORITY(TOP_PRIORITY)) u_dp (
    .clk, .rst_n, .cmd, .stat,
    .opcode        (in_ch.opcode),
    .priority_req  (in_ch.priority_req),
    .timeout       (in_ch.timeout),
    .task_index    (in_ch.task_index),
    .status        (out_ch.status),
    .new_task_index(out_ch.new_task_index),
    .running_task  (out_ch.running_task),
    .switched      (out_ch.switched),
    .tick_count    (out_ch.tick_count)
  );
endmodule
`default_nettype wire

// File: design/pts_ctrl.sv
// Controller state machine for the scheduler: sequences the table walks.
// Depends on pts_pkg.
`default_nettype none
module pts_ctrl
  import pts_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  input  wire pts_stat_t stat,
  output pts_cmd_t       cmd
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          cmd.clr_walk = 1'b1;
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if (!stat.need_walk) begin
          state_nxt = S_FIN;
        end else begin
          cmd.step = 1'b1;
          if (stat.walk_last) state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end
endmodule
`default_nettype wire

// File: design/pts_dp.sv
// Datapath for the scheduler: task table, tick counter, walk and selection.
// Depends on pts_pkg.
`default_nettype none
module pts_dp
  import pts_pkg::*;
#(
  parameter int TASK_SLOTS   = 32,
  parameter int TOP_PRIORITY = 7
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire pts_cmd_t    cmd,
  output pts_stat_t        stat,
  input  wire logic [2:0]  opcode,
  input  wire logic [2:0]  priority_req,
  input  wire logic [31:0] timeout,
  input  wire logic [4:0]  task_index,
  output logic [1:0]       status,
  output logic [4:0]       new_task_index,
  output logic [4:0]       running_task,
  output logic             switched,
  output logic [31:0]      tick_count
);
  localparam int IW = $clog2(TASK_SLOTS);
  localparam int CW = $clog2(TASK_SLOTS + 1);
  localparam logic [2:0] PRIO_CAP = (TOP_PRIORITY > 7) ? 3'd7 : 3'(TOP_PRIORITY);

  logic [1:0]  tstat_r [TASK_SLOTS];
  logic [2:0]  tprio_r [TASK_SLOTS];
  logic [31:0] ttmo_r  [TASK_SLOTS];

  logic [CW-1:0] total_r;
  logic [IW-1:0] cur_r;
  logic          started_r;
  logic [31:0]   ticks_r;

  logic [2:0]    op_r;
  logic [IW-1:0] walk_r;
  logic [2:0]    best_prio_r;
  logic [IW-1:0] choice_r;
  logic          walking_r;  // tick/block/start active
  logic          tickop_r;   // countdown applies

  logic [1:0]  status_r;
  logic [4:0]  newidx_r;
  logic        sw_r;

  logic cur_ok, go_tick, go_start;
  logic [2:0] prio_c;
  logic [1:0] st_now;
  logic [31:0] tm_dec;
  logic [IW-1:0] ridx;
  logic ridx_ok;

  assign cur_ok   = started_r && (total_r != '0);
  assign go_start = (opcode == OP_START) && (total_r != '0) && !started_r;
  assign go_tick  = ((opcode == OP_TICK) || (opcode == OP_BLOCK)) && cur_ok;
  assign prio_c   = (priority_req > PRIO_CAP) ? PRIO_CAP : priority_req;
  assign ridx     = task_index[IW-1:0];
  assign ridx_ok  = ({1'b0, task_index} < 6'(total_r)) && (32'(task_index) < TASK_SLOTS);

  assign stat.need_walk = walking_r;
  assign stat.walk_last = (CW'(walk_r) + 1'b1) >= total_r;

  // entry under walk after its countdown
  always_comb begin
    st_now = tstat_r[walk_r];
    tm_dec = ttmo_r[walk_r] - 32'd1;
    if (tickop_r && st_now == TS_BLOCKED && ttmo_r[walk_r] != 32'd0 && tm_dec == 32'd0)
      st_now = TS_READY;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r   <= '0;
      cur_r     <= '0;
      started_r <= 1'b0;
      ticks_r   <= '0;
      walking_r <= 1'b0;
      tickop_r  <= 1'b0;
    end else begin
      if (cmd.load) begin
        op_r <= opcode;
        status_r <= RES_IGNORED;
        newidx_r <= '0;
        sw_r <= 1'b0;
        walking_r <= go_start || go_tick;
        tickop_r <= go_tick;
        best_prio_r <= '0;
        choice_r <= cur_r;
        unique case (opcode)
          OP_CREATE: begin
            if (total_r >= CW'(TASK_SLOTS)) begin
              status_r <= RES_FULL;
            end else begin
              tstat_r[total_r[IW-1:0]] <= TS_READY;
              tprio_r[total_r[IW-1:0]] <= prio_c;
              ttmo_r[total_r[IW-1:0]]  <= '0;
              newidx_r <= 5'(total_r);
              total_r <= total_r + 1'b1;
              status_r <= RES_DONE;
            end
          end
          OP_START: ;
          OP_TICK: if (go_tick) ticks_r <= ticks_r + 32'd1;
          OP_BLOCK: begin
            if (go_tick) begin
              tstat_r[cur_r] <= TS_BLOCKED;
              ttmo_r[cur_r]  <= timeout;
              ticks_r <= ticks_r + 32'd1;
            end
          end
          OP_RESUME: begin
            if (ridx_ok) begin
              if (tstat_r[ridx] == TS_BLOCKED) begin
                tstat_r[ridx] <= TS_READY;
                ttmo_r[ridx]  <= '0;
              end
              status_r <= RES_DONE;
            end
          end
          default: ;
        endcase
      end
      if (cmd.clr_walk) walk_r <= '0;
      if (cmd.step && walking_r) begin
        if (tickop_r && tstat_r[walk_r] == TS_BLOCKED && ttmo_r[walk_r] != 32'd0) begin
          ttmo_r[walk_r] <= tm_dec;
          if (tm_dec == 32'd0) tstat_r[walk_r] <= TS_READY;
        end
        if (st_now == TS_READY && tprio_r[walk_r] > best_prio_r) begin
          best_prio_r <= tprio_r[walk_r];
          choice_r <= walk_r;
        end
        walk_r <= walk_r + 1'b1;
      end
      if (cmd.finish && walking_r) begin
        walking_r <= 1'b0;
        status_r <= RES_DONE;
        if (op_r == OP_START) begin
          started_r <= 1'b1;
          cur_r <= choice_r;
          tstat_r[choice_r] <= TS_RUNNING;
          sw_r <= 1'b1;
        end else if (choice_r != cur_r) begin
          if (tstat_r[cur_r] != TS_BLOCKED) tstat_r[cur_r] <= TS_READY;
          tstat_r[choice_r] <= TS_RUNNING;
          cur_r <= choice_r;
          sw_r <= 1'b1;
        end
      end
    end
  end

  assign status = status_r;
  assign new_task_index = newidx_r;
  assign running_task = 5'(cur_r);
  assign switched = sw_r;
  assign tick_count = ticks_r;
endmodule
`default_nettype wire
